>>> rtl/core/hlhc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlhc_pkg: shared types and constants for the heap compactor
// Field widths, item kinds, controller states and the command/status bundles
// passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package hlhc_pkg;

	// defaults for the top-level parameters
	localparam int HEAP_WORDS_DEF = 1024;
	localparam int WORD_BITS_DEF  = 32;

	// field widths on the stream ports
	localparam int KIND_W   = 2;
	localparam int SLOT_W   = 10;
	localparam int DATA_W   = 32;
	localparam int OFF_W    = 11;
	localparam int HSIZE_W  = 11;
	localparam int HSTART_W = 10;

	localparam int IN_FIELDS_W  = SLOT_W + DATA_W + 1;
	localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = DATA_W + 1 + OFF_W + HSIZE_W + HSTART_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	// item kinds
	localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_READ    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_COMPACT = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_PREP,
		ST_MOVE,
		ST_RESULT
	} hlhc_state_t;

	typedef struct packed {
		logic clr;
		logic accept;
		logic scan;
		logic move_init;
		logic move;
		logic load_out;
	} hlhc_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic scan_done;
		logic move_done;
	} hlhc_sts_t;

	// result word, last field in the lowest bits
	typedef struct packed {
		logic [HSTART_W-1:0]     hole_start;
		logic [HSIZE_W-1:0]      hole_size;
		logic signed [OFF_W-1:0] roffset;
		logic                    roccupied;
		logic [DATA_W-1:0]       rdata;
	} hlhc_res_t;

endpackage

>>> rtl/core/hlhc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlhc_ctrl: sequencing FSM for the heap compactor
// Runs the clearing pass, takes one word at a time, steps the datapath through
// scan and move passes and owns the output valid flag.
// ----------------------------------------------------------------------------
module hlhc_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [hlhc_pkg::KIND_W-1:0] in_kind,
	output logic                      in_ready,
	output logic                      out_valid,
	input  logic                      out_ready,
	input  hlhc_pkg::hlhc_sts_t       sts,
	output hlhc_pkg::hlhc_cmd_t       cmd
);

	hlhc_pkg::hlhc_state_t state_q, state_d;
	logic                  out_valid_q;
	logic                  out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hlhc_pkg::ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			hlhc_pkg::ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) begin
					state_d = hlhc_pkg::ST_IDLE;
				end
			end
			hlhc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (in_kind == hlhc_pkg::KIND_COMPACT) begin
						state_d = hlhc_pkg::ST_SCAN;
					end else begin
						state_d = hlhc_pkg::ST_RESULT;
					end
				end
			end
			hlhc_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					state_d = hlhc_pkg::ST_PREP;
				end
			end
			hlhc_pkg::ST_PREP: begin
				// hole and stop are final here
				cmd.move_init = 1'b1;
				state_d       = hlhc_pkg::ST_MOVE;
			end
			hlhc_pkg::ST_MOVE: begin
				cmd.move = 1'b1;
				if (sts.move_done) begin
					state_d = hlhc_pkg::ST_RESULT;
				end
			end
			hlhc_pkg::ST_RESULT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = hlhc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = hlhc_pkg::ST_IDLE;
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_result_handoff: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hlhc_pkg::ST_RESULT && out_free) |=>
		(state_q == hlhc_pkg::ST_IDLE && out_valid_q))
		else $error("result not handed to output register");
`endif

endmodule

>>> rtl/core/hlhc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlhc_dp: storage and passes of the heap compactor
// Heap, occupancy and offset memories, the clearing counter, the scan stage
// that finds the largest closed hole and the move stage that slides words down.
// ----------------------------------------------------------------------------
module hlhc_dp #(
	parameter int HEAP_WORDS = hlhc_pkg::HEAP_WORDS_DEF,
	parameter int WORD_BITS  = hlhc_pkg::WORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  hlhc_pkg::hlhc_cmd_t           cmd,
	output hlhc_pkg::hlhc_sts_t           sts,
	input  logic [hlhc_pkg::KIND_W-1:0]   kind,
	input  logic [hlhc_pkg::SLOT_W-1:0]   slot,
	input  logic [hlhc_pkg::DATA_W-1:0]   wdata,
	input  logic                          woccupied,
	output hlhc_pkg::hlhc_res_t           res
);

	localparam int AW = $clog2(HEAP_WORDS);
	localparam int CW = $clog2(HEAP_WORDS + 1);
	localparam int SW = (WORD_BITS < hlhc_pkg::DATA_W) ? WORD_BITS : hlhc_pkg::DATA_W;
	localparam logic [AW-1:0] LAST = AW'(HEAP_WORDS - 1);
	localparam logic [CW-1:0] NW   = CW'(HEAP_WORDS);

	logic [SW-1:0]                heap_mem [HEAP_WORDS];
	logic                         occ_mem  [HEAP_WORDS];
	logic [hlhc_pkg::OFF_W-1:0]   off_mem  [HEAP_WORDS];

	logic [SW-1:0]                heap_rd_q;
	logic                         occ_rd_q;
	logic [hlhc_pkg::OFF_W-1:0]   off_rd_q;

	logic [AW-1:0]                item_slot;
	logic                         slot_ok;
	logic                         is_write, is_read;

	logic [AW-1:0]                clr_q;
	logic [CW-1:0]                scan_cnt_q, dest_cnt_q;
	logic                         scan_issue, move_issue;
	logic [CW:0]                  src_sum;
	logic                         src_ok;

	logic                         scan_v_s1;
	logic [AW-1:0]                scan_idx_s1;
	logic [CW-1:0]                run_q, hole_q;
	logic [AW-1:0]                stop_q;
	logic [AW-1:0]                start_v;

	logic                         mv_v_s1, src_ok_s1;
	logic [AW-1:0]                dest_s1, src_s1;
	logic                         mv_hit;
	logic [hlhc_pkg::OFF_W-1:0]   hole_off, neg_hole;

	logic [hlhc_pkg::KIND_W-1:0]  kind_q;
	logic                         rd_ok_q;
	hlhc_pkg::hlhc_res_t          res_d;

	logic                         occ_ren, heap_ren, off_ren;
	logic [AW-1:0]                occ_raddr, heap_raddr;
	logic                         occ_we, heap_we, off_we;
	logic [AW-1:0]                occ_waddr, heap_waddr, off_waddr;
	logic                         occ_wdata;
	logic [SW-1:0]                heap_wdata;
	logic [hlhc_pkg::OFF_W-1:0]   off_wdata;

	assign item_slot = AW'(slot);
	assign slot_ok   = {{(32 - hlhc_pkg::SLOT_W){1'b0}}, slot} < 32'(HEAP_WORDS);
	assign is_write  = cmd.accept && kind == hlhc_pkg::KIND_WRITE && slot_ok;
	assign is_read   = cmd.accept && kind == hlhc_pkg::KIND_READ && slot_ok;

	assign scan_issue = cmd.scan && scan_cnt_q < NW;
	assign move_issue = cmd.move && dest_cnt_q < NW;
	assign src_sum    = {1'b0, dest_cnt_q} + {1'b0, hole_q};
	assign src_ok     = src_sum < (CW + 1)'(HEAP_WORDS);

	assign start_v  = stop_q - hole_q[AW-1:0];
	assign hole_off = hlhc_pkg::OFF_W'(hole_q);
	assign neg_hole = -hole_off;
	// destination takes the source word only when the source was occupied
	assign mv_hit   = mv_v_s1 && src_ok_s1 && occ_rd_q;

	// read ports
	always_comb begin
		occ_ren  = is_read || scan_issue || (move_issue && src_ok);
		heap_ren = is_read || (move_issue && src_ok);
		off_ren  = is_read;
		if (is_read) begin
			occ_raddr = item_slot;
		end else if (scan_issue) begin
			occ_raddr = scan_cnt_q[AW-1:0];
		end else begin
			occ_raddr = src_sum[AW-1:0];
		end
		heap_raddr = is_read ? item_slot : src_sum[AW-1:0];
	end

	// write ports
	always_comb begin
		occ_we     = 1'b0;
		occ_waddr  = clr_q;
		occ_wdata  = 1'b0;
		heap_we    = 1'b0;
		heap_waddr = item_slot;
		heap_wdata = wdata[SW-1:0];
		off_we     = 1'b0;
		off_waddr  = clr_q;
		off_wdata  = '0;
		if (cmd.clr) begin
			occ_we = 1'b1;
			off_we = 1'b1;
		end else if (is_write) begin
			occ_we    = 1'b1;
			occ_waddr = item_slot;
			occ_wdata = woccupied;
			heap_we   = 1'b1;
		end else if (mv_v_s1) begin
			// every destination ends with the occupancy of its source, or free when the source lies past the heap end
			occ_we     = 1'b1;
			occ_waddr  = dest_s1;
			occ_wdata  = src_ok_s1 && occ_rd_q;
			heap_we    = mv_hit;
			heap_waddr = dest_s1;
			heap_wdata = heap_rd_q;
			off_we     = mv_hit;
			off_waddr  = src_s1;
			off_wdata  = neg_hole;
		end
	end

	always_ff @(posedge clk) begin
		if (occ_ren) begin
			occ_rd_q <= occ_mem[occ_raddr];
		end
		if (heap_ren) begin
			heap_rd_q <= heap_mem[heap_raddr];
		end
		if (off_ren) begin
			off_rd_q <= off_mem[item_slot];
		end
		if (occ_we) begin
			occ_mem[occ_waddr] <= occ_wdata;
		end
		if (heap_we) begin
			heap_mem[heap_waddr] <= heap_wdata;
		end
		if (off_we) begin
			off_mem[off_waddr] <= off_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			scan_cnt_q  <= '0;
			dest_cnt_q  <= '0;
			scan_v_s1   <= 1'b0;
			scan_idx_s1 <= '0;
			run_q       <= '0;
			hole_q      <= '0;
			stop_q      <= '0;
			mv_v_s1     <= 1'b0;
			src_ok_s1   <= 1'b0;
			dest_s1     <= '0;
			src_s1      <= '0;
			kind_q      <= hlhc_pkg::KIND_WRITE;
			rd_ok_q     <= 1'b0;
		end else begin
			if (cmd.clr) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.accept) begin
				kind_q     <= kind;
				rd_ok_q    <= slot_ok;
				scan_cnt_q <= '0;
			end else if (scan_issue) begin
				scan_cnt_q <= scan_cnt_q + 1'b1;
			end
			scan_v_s1   <= scan_issue;
			scan_idx_s1 <= scan_cnt_q[AW-1:0];

			// longest free run closed by an occupied word, first one wins
			if (cmd.accept && kind == hlhc_pkg::KIND_COMPACT) begin
				run_q  <= '0;
				hole_q <= '0;
				stop_q <= '0;
			end else if (scan_v_s1) begin
				if (!occ_rd_q) begin
					run_q <= run_q + 1'b1;
				end else begin
					if (run_q > hole_q) begin
						hole_q <= run_q;
						stop_q <= scan_idx_s1;
					end
					run_q <= '0;
				end
			end

			if (cmd.move_init) begin
				dest_cnt_q <= CW'(start_v);
			end else if (move_issue) begin
				dest_cnt_q <= dest_cnt_q + 1'b1;
			end
			mv_v_s1   <= move_issue;
			src_ok_s1 <= src_ok;
			dest_s1   <= dest_cnt_q[AW-1:0];
			src_s1    <= src_sum[AW-1:0];
		end
	end

	assign sts.clr_last  = clr_q == LAST;
	assign sts.scan_done = scan_v_s1 && scan_idx_s1 == LAST;
	assign sts.move_done = mv_v_s1 && dest_s1 == LAST;

	always_comb begin
		res_d = '0;
		if (kind_q == hlhc_pkg::KIND_READ && rd_ok_q) begin
			res_d.rdata     = hlhc_pkg::DATA_W'(heap_rd_q);
			res_d.roccupied = occ_rd_q;
			res_d.roffset   = off_rd_q;
		end
		if (kind_q == hlhc_pkg::KIND_COMPACT) begin
			res_d.hole_size  = hlhc_pkg::HSIZE_W'(hole_q);
			res_d.hole_start = hlhc_pkg::HSTART_W'(start_v);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			res <= res_d;
		end
	end

`ifndef ASSERT_OFF
	a_one_pass: assert property (@(posedge clk) disable iff (!arst_n)
		!(scan_v_s1 && mv_v_s1))
		else $error("scan and move stages active together");
	a_move_down: assert property (@(posedge clk) disable iff (!arst_n)
		(mv_v_s1 && src_ok_s1) |-> dest_s1 <= src_s1)
		else $error("move writes above its source");
	a_hole_fits: assert property (@(posedge clk) disable iff (!arst_n)
		hole_q <= CW'(stop_q))
		else $error("hole longer than its closing index");
`endif

endmodule

>>> rtl/core/heap_largest_hole_compactor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heap_largest_hole_compactor_top: heap store with largest-hole compaction
//
// channel  dir  handshake         payload
// s_*      in   tvalid / tready   tuser: kind; tdata: slot, wdata, woccupied
// m_*      out  tvalid / tready   tdata: rdata, roccupied, roffset,
//                                        hole_size, hole_start
//
// After reset a clearing pass over all HEAP_WORDS words runs with s_tready low.
// Write, read and unused kinds skip the scan and move passes.
// Compaction runs a scan pass with one occupancy read a cycle, then a move
// pass with one heap move a cycle from hole_start up.
// One word is worked on at a time; the next is taken while a result waits in
// the output register, and only the final hand-off waits on m_tready.
// ----------------------------------------------------------------------------
module heap_largest_hole_compactor_top #(
	parameter int HEAP_WORDS = hlhc_pkg::HEAP_WORDS_DEF,
	parameter int WORD_BITS  = hlhc_pkg::WORD_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// slot, wdata, woccupied
	input  logic [hlhc_pkg::IN_TDATA_W-1:0]      s_tdata,
	// kind
	input  logic [hlhc_pkg::KIND_W-1:0]          s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// rdata, roccupied, roffset, hole_size, hole_start
	output logic [hlhc_pkg::OUT_TDATA_W-1:0]     m_tdata
);

	localparam int SLOT_LO = 0;
	localparam int WDATA_LO = SLOT_LO + hlhc_pkg::SLOT_W;
	localparam int WOCC_LO  = WDATA_LO + hlhc_pkg::DATA_W;

	hlhc_pkg::hlhc_cmd_t cmd;
	hlhc_pkg::hlhc_sts_t sts;
	hlhc_pkg::hlhc_res_t res;

	hlhc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_kind   (s_tuser),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	hlhc_dp #(
		.HEAP_WORDS (HEAP_WORDS),
		.WORD_BITS  (WORD_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.kind      (s_tuser),
		.slot      (s_tdata[WDATA_LO-1:SLOT_LO]),
		.wdata     (s_tdata[WOCC_LO-1:WDATA_LO]),
		.woccupied (s_tdata[WOCC_LO]),
		.res       (res)
	);

	assign m_tdata = {{(hlhc_pkg::OUT_TDATA_W - hlhc_pkg::OUT_FIELDS_W){1'b0}}, res};

endmodule
